@@ design/jsd_pkg.sv @@
// Shared types and constants for the JIS / Shift-JIS to EUC decoder.
`timescale 1ns / 1ps

package jsd_pkg;

    // Decoder shift state
    typedef enum logic [1:0] {
        DS_ASCII     = 2'd0,
        DS_LEAD      = 2'd1,
        DS_JIS_FIRST = 2'd2,
        DS_JIS_KANJI = 2'd3
    } jsd_dstate_t;

    // Escape sequence progress; the fourth code is unused
    typedef enum logic [1:0] {
        EP_NONE     = 2'd0,
        EP_AFTER_ESC = 2'd1,
        EP_AFTER_SEL = 2'd2
    } jsd_ephase_t;

    // One decoded job: one or two result bytes
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       bad;
    } jsd_job_t;

    localparam logic [7:0] ESC_BYTE      = 8'h1B;
    localparam logic [7:0] NL_BYTE       = 8'h0A;
    localparam logic [7:0] DOLLAR_BYTE   = 8'h24;
    localparam logic [7:0] LPAREN_BYTE   = 8'h28;
    localparam logic [7:0] QMARK_BYTE    = 8'h3F;
    localparam logic [7:0] CTRL_LIMIT    = 8'h20;
    localparam logic [7:0] BAD_LEAD      = 8'hA2;
    localparam logic [7:0] BAD_TRAIL     = 8'hA3;

    localparam int unsigned CFG_SOURCE_CODE = 0;

endpackage

@@ design/jsd_front.sv @@
// Front end: accepts input bytes, tracks escape and shift state, builds jobs.
`timescale 1ns / 1ps

module jsd_front import jsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       source_code,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    output logic       job_push,
    output jsd_job_t   job
);

    jsd_dstate_t dstate_reg, dstate_next;
    jsd_ephase_t ephase_reg, ephase_next;
    logic [7:0]  pend_reg, pend_next;
    logic        etarget_reg, etarget_next;
    logic        job_valid;

    logic [7:0]  pa, pb, sa, sb, sj1, sj2, dbl;

    // Lead / trail pair selection and range check
    function automatic jsd_job_t make_pair(input logic [7:0] c1, input logic [7:0] c2);
        jsd_job_t j;
        j.two = 1'b1;
        j.bad = 1'b0;
        if (c1 < 8'hA1 || (c1 >= 8'hA9 && c1 <= 8'hAF) || c1 >= 8'hF5) begin
            j.b0 = BAD_LEAD;
            j.b1 = BAD_TRAIL;
        end else begin
            j.b0 = c1;
            j.b1 = c2;
        end
        return j;
    endfunction

    // Shift-JIS arithmetic, 8-bit wrap
    always_comb begin
        dbl = {pend_reg[6:0], 1'b0};
        if (in_byte >= 8'h9F) begin
            sj1 = (pend_reg >= 8'hE0) ? dbl - 8'hE0 : dbl - 8'h60;
            sj2 = in_byte + 8'h02;
        end else begin
            sj1 = (pend_reg >= 8'hE0) ? dbl - 8'hE1 : dbl - 8'h61;
            sj2 = (in_byte >= 8'h7F) ? in_byte + 8'h60 : in_byte + 8'h61;
        end
        if (source_code) begin
            pa = sj1;
            pb = sj2;
        end else begin
            pa = pend_reg;
            pb = in_byte;
        end
        sa = pend_reg | 8'h80;
        sb = in_byte | 8'h80;
    end

    always_comb begin
        dstate_next  = dstate_reg;
        ephase_next  = EP_NONE;
        pend_next    = pend_reg;
        etarget_next = etarget_reg;
        job_valid    = 1'b0;
        job          = '{two: 1'b0, b0: in_byte, b1: in_byte, bad: 1'b0};
        unique case (ephase_reg)
            EP_AFTER_ESC: begin
                if (in_byte == DOLLAR_BYTE) begin
                    etarget_next = 1'b1;
                    ephase_next  = EP_AFTER_SEL;
                end else if (in_byte == LPAREN_BYTE) begin
                    etarget_next = 1'b0;
                    ephase_next  = EP_AFTER_SEL;
                end else begin
                    job_valid = 1'b1;
                    job.b0    = 8'h00;
                    job.bad   = 1'b1;
                end
            end
            EP_AFTER_SEL: begin
                dstate_next = etarget_reg ? DS_JIS_KANJI : DS_ASCII;
            end
            default: begin
                if (in_byte == NL_BYTE) begin
                    job_valid = 1'b1;
                end else begin
                    unique case (dstate_reg)
                        DS_ASCII: begin
                            if (in_byte == ESC_BYTE) begin
                                ephase_next = EP_AFTER_ESC;
                            end else if (!source_code) begin
                                if (in_byte[7]) begin
                                    pend_next   = in_byte;
                                    dstate_next = DS_LEAD;
                                end else begin
                                    job_valid = 1'b1;
                                end
                            end else if (in_byte >= 8'hE0 || (in_byte[7] && in_byte < 8'hA0)) begin
                                pend_next   = in_byte;
                                dstate_next = DS_LEAD;
                            end else begin
                                job_valid = 1'b1;
                                job.b0    = in_byte[7] ? QMARK_BYTE : in_byte;
                            end
                        end
                        DS_LEAD: begin
                            dstate_next = DS_ASCII;
                            job_valid   = 1'b1;
                            job         = make_pair(pa, pb);
                        end
                        DS_JIS_FIRST: begin
                            dstate_next = DS_JIS_KANJI;
                            job_valid   = 1'b1;
                            job         = make_pair(sa, sb);
                        end
                        default: begin
                            if (in_byte == ESC_BYTE) begin
                                ephase_next = EP_AFTER_ESC;
                            end else if (in_byte < CTRL_LIMIT) begin
                                job_valid = 1'b1;
                            end else begin
                                pend_next   = in_byte;
                                dstate_next = DS_JIS_FIRST;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    assign job_push = in_fire && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dstate_reg  <= DS_ASCII;
            ephase_reg  <= EP_NONE;
            pend_reg    <= 8'h00;
            etarget_reg <= 1'b0;
        end else if (in_fire) begin
            dstate_reg  <= dstate_next;
            ephase_reg  <= ephase_next;
            pend_reg    <= pend_next;
            etarget_reg <= etarget_next;
        end
    end

endmodule

@@ design/jsd_queue.sv @@
// Small job queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module jsd_queue import jsd_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  jsd_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output jsd_job_t head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    jsd_job_t      mem [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/jsd_back.sv @@
// Output sequencer: expands queued jobs into one or two result transactions.
`timescale 1ns / 1ps

module jsd_back import jsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  jsd_job_t   q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last,
    output logic       m_bad_escape
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg, bad_reg;
    logic       second_reg;      // trail byte still owed
    logic [7:0] trail_reg;
    logic       out_free;

    assign out_free = !valid_reg || m_ready;
    assign q_pop    = out_free && !second_reg && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else if (out_free) begin
            if (second_reg) begin
                valid_reg  <= 1'b1;
                second_reg <= 1'b0;
            end else begin
                valid_reg  <= q_valid;
                second_reg <= q_valid && q_head.two;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (second_reg) begin
                byte_reg <= trail_reg;
                last_reg <= 1'b1;
                bad_reg  <= 1'b0;
            end else if (q_valid) begin
                byte_reg  <= q_head.b0;
                last_reg  <= !q_head.two;
                bad_reg   <= q_head.bad;
                trail_reg <= q_head.b1;
            end
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_out_last   = last_reg;
    assign m_bad_escape = bad_reg;

endmodule

@@ design/jis_sjis_to_euc_decoder.sv @@
// Top level of the JIS / Shift-JIS to EUC byte stream decoder.
`timescale 1ns / 1ps

// Converts a Japanese text byte stream to EUC, one byte per input
// transaction. source_code (APB register at any address, bit 0) picks the
// input form: 0 = JIS escapes or raw EUC, 1 = Shift-JIS. Each input byte
// yields zero, one or two result transactions; out_last marks the final
// result of a byte and bad_escape flags an unrecognized escape sequence.
// The front end takes one byte every cycle while the job queue has room;
// a job (one or two bytes) goes through a QUEUE_DEPTH-entry queue to the
// output sequencer, which sends one result per cycle while m_ready is high.
// Sustained input rate is one byte per cycle for single-result bytes with
// m_ready high; a byte ending a kanji pair yields two results, so pair-heavy
// streams run at the output port's one-result-per-cycle rate. Each result is
// held in an output register. Write source_code only while the block is idle.
module jis_sjis_to_euc_decoder import jsd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_last,
    output logic        m_bad_escape,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic     source_code_reg;
    logic     in_fire;
    logic     job_push, q_full, q_pop, q_valid;
    jsd_job_t job, q_head;

    // APB register file: one bit, pready tied high
    assign pready = 1'b1;
    assign prdata = (32'(paddr) >> 2 == 32'(CFG_SOURCE_CODE))
                    ? {31'b0, source_code_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_code_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            source_code_reg <= pwdata[0];
        end
    end

    // front end stalls only when the queue is full
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    jsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .source_code (source_code_reg),
        .in_fire     (in_fire),
        .in_byte     (s_in_byte),
        .job_push    (job_push),
        .job         (job)
    );

    jsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_job  (job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    jsd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_last   (m_out_last),
        .m_bad_escape (m_bad_escape)
    );

endmodule
